// ===== design/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Shared widths, status codes, multiplier operand selects and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pca_pkg;

  // default frame size limit
  localparam int VERTEX_MAX_DEF = 256;

  // field and accumulator widths
  localparam int COORD_W    = 16;
  localparam int CROSS_W    = 42;
  localparam int WSUM_W     = 59;
  localparam int DEN_W      = 44;
  localparam int AREA_W     = 40;
  localparam int STATUS_W   = 3;
  localparam int PP_W       = 2 * COORD_W;        // one coordinate product
  localparam int MA_W       = PP_W + 1;           // cross product term
  localparam int MB_W       = COORD_W + 1;        // coordinate pair sum
  localparam int PROD_W     = MA_W + MB_W;
  localparam int IN_TDATA_W = 2 * COORD_W;
  localparam int OUT_DATA_W = AREA_W + 2 * COORD_W;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_POLYGON   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MIDPOINT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_AREA = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  // multiplier operand selects
  localparam int MUL_SEL_W = 2;
  localparam logic [MUL_SEL_W-1:0] MUL_PX_Y = 2'd0;  // prev x * cur y
  localparam logic [MUL_SEL_W-1:0] MUL_X_PY = 2'd1;  // cur x * prev y
  localparam logic [MUL_SEL_W-1:0] MUL_C_SX = 2'd2;  // cross * (prev x + cur x)
  localparam logic [MUL_SEL_W-1:0] MUL_C_SY = 2'd3;  // cross * (prev y + cur y)

  // controller to datapath commands
  typedef struct packed {
    logic                 load_in;
    logic                 vtx_first;
    logic                 advance;
    logic                 set_ovf;
    logic                 mul_en;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 hold_t;
    logic                 calc_c;
    logic                 acc_cross;
    logic                 acc_wx;
    logic                 acc_wy;
    logic                 load_den;
    logic                 div_start;
    logic                 div_sel_y;
    logic                 cap_cx;
    logic                 cap_cy;
    logic                 load_out;
  } pca_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic last;
    logic need_div;
    logic div_done;
    logic out_free;
  } pca_stat_t;

endpackage

// ===== design/pca_div.sv =====
// ----------------------------------------------------------------------------
// pca_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero, with the quotient saturated to a 16-bit coordinate.
// ----------------------------------------------------------------------------
module pca_div import pca_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [WSUM_W-1:0]  num,
  input  logic signed [DEN_W-1:0]   den,
  output logic                      done,
  output logic signed [COORD_W-1:0] quo
);

  localparam int CNT_W = $clog2(WSUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WSUM_W - 1);
  localparam logic [WSUM_W-1:0] POS_MAX = WSUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic [WSUM_W-1:0] NEG_MAX = WSUM_W'(1 << (COORD_W - 1));

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WSUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [MB_W-1:0]   neg_q;

  // one restoring step
  assign trial = {rem_r, num_r[WSUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      num_nxt = num[WSUM_W-1] ? WSUM_W'(-num) : WSUM_W'(num);
      den_nxt = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg_nxt = num[WSUM_W-1] ^ den[DEN_W-1];
    end else if (run_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_nxt = {num_r[WSUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // sign and saturate the magnitude quotient
  assign neg_q = MB_W'(0) - num_r[MB_W-1:0];

  always_comb begin
    if (neg_r) begin
      quo = (num_r > NEG_MAX) ? $signed(NEG_MAX[COORD_W-1:0]) : $signed(neg_q[COORD_W-1:0]);
    end else begin
      quo = (num_r > POS_MAX) ? $signed(POS_MAX[COORD_W-1:0]) : $signed(num_r[COORD_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

// ===== design/pca_dp.sv =====
// ----------------------------------------------------------------------------
// pca_dp
// Datapath: vertex registers, shared multiplier, shoelace accumulators,
// centroid divider and the result register.
// ----------------------------------------------------------------------------
module pca_dp import pca_pkg::*; #(
  parameter int MAX_VERTICES = VERTEX_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic                      in_last,
  input  pca_cmd_t                  cmd,
  output pca_stat_t                 stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [AREA_W-1:0]  out_area,
  output logic signed [COORD_W-1:0] out_cx,
  output logic signed [COORD_W-1:0] out_cy,
  output logic [STATUS_W-1:0]       out_status
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // current vertex and frame state
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r;
  logic                      cur_last_r;
  logic signed [COORD_W-1:0] first_x_r, first_y_r;
  logic signed [COORD_W-1:0] second_x_r, second_y_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [CROSS_W-1:0] cross_r;
  logic signed [WSUM_W-1:0]  wx_r, wy_r;
  logic                      ovf_r;

  // multiply pipeline
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PP_W-1:0]    t_r;
  logic signed [MA_W-1:0]    c_r;

  // finishing
  logic signed [DEN_W-1:0]   den_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic                      div_done;
  logic signed [COORD_W-1:0] div_quo;

  // result register
  logic                      out_valid_r;
  logic signed [AREA_W-1:0]  out_area_r;
  logic signed [COORD_W-1:0] out_cx_r, out_cy_r;
  logic [STATUS_W-1:0]       out_status_r;

  logic                      cnt_gt3, cnt_eq3;
  logic signed [MB_W-1:0]    mid_sx, mid_sy, mid_ax, mid_ay;
  logic signed [CROSS_W-1:0] area_adj;
  logic signed [AREA_W-1:0]  res_area;
  logic signed [COORD_W-1:0] res_cx, res_cy;
  logic [STATUS_W-1:0]       res_status;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_PX_Y: begin
        mul_a = MA_W'(prev_x_r);
        mul_b = MB_W'(cur_y_r);
      end
      MUL_X_PY: begin
        mul_a = MA_W'(cur_x_r);
        mul_b = MB_W'(prev_y_r);
      end
      MUL_C_SX: begin
        mul_a = c_r;
        mul_b = MB_W'(prev_x_r) + MB_W'(cur_x_r);
      end
      MUL_C_SY: begin
        mul_a = c_r;
        mul_b = MB_W'(prev_y_r) + MB_W'(cur_y_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // vertex, count and accumulate registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      first_x_r  <= '0;
      first_y_r  <= '0;
      second_x_r <= '0;
      second_y_r <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      cnt_r      <= '0;
      cross_r    <= '0;
      wx_r       <= '0;
      wy_r       <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (cmd.vtx_first) begin
        first_x_r <= cur_x_r;
        first_y_r <= cur_y_r;
      end
      if (cmd.advance) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
        cnt_r    <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          second_x_r <= cur_x_r;
          second_y_r <= cur_y_r;
        end
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.acc_cross) begin
        cross_r <= cross_r + CROSS_W'(c_r);
      end
      if (cmd.acc_wx) begin
        wx_r <= wx_r + WSUM_W'(prod_r);
      end
      if (cmd.acc_wy) begin
        wy_r <= wy_r + WSUM_W'(prod_r);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_x_r    <= in_x;
      cur_y_r    <= in_y;
      cur_last_r <= in_last;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.hold_t) begin
      t_r <= $signed(prod_r[PP_W-1:0]);
    end
    if (cmd.calc_c) begin
      c_r <= MA_W'(t_r) - MA_W'($signed(prod_r[PP_W-1:0]));
    end
    if (cmd.load_den) begin
      den_r <= DEN_W'(cross_r) + (DEN_W'(cross_r) <<< 1);
    end
    if (cmd.cap_cx) begin
      cx_r <= div_quo;
    end
    if (cmd.cap_cy) begin
      cy_r <= div_quo;
    end
  end

  // centroid divider, shared by both axes
  pca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel_y ? wy_r : wx_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result selection by frame case
  assign cnt_gt3  = (cnt_r > CNT_W'(3));
  assign cnt_eq3  = (cnt_r == CNT_W'(3));
  assign mid_sx   = MB_W'(first_x_r) + MB_W'(second_x_r);
  assign mid_sy   = MB_W'(first_y_r) + MB_W'(second_y_r);
  assign mid_ax   = mid_sx + $signed({{(MB_W-1){1'b0}}, mid_sx[MB_W-1]});
  assign mid_ay   = mid_sy + $signed({{(MB_W-1){1'b0}}, mid_sy[MB_W-1]});
  assign area_adj = cross_r + $signed({{(CROSS_W-1){1'b0}}, cross_r[CROSS_W-1]});

  always_comb begin
    res_area   = '0;
    res_cx     = '0;
    res_cy     = '0;
    res_status = ST_TOO_FEW;
    if (ovf_r) begin
      res_status = ST_OVERFLOW;
    end else if (cnt_gt3) begin
      if (cross_r != '0) begin
        res_area   = $signed(area_adj[AREA_W:1]);
        res_cx     = cx_r;
        res_cy     = cy_r;
        res_status = ST_POLYGON;
      end else begin
        res_status = ST_ZERO_AREA;
      end
    end else if (cnt_eq3) begin
      res_cx     = $signed(mid_ax[COORD_W:1]);
      res_cy     = $signed(mid_ay[COORD_W:1]);
      res_status = ST_MIDPOINT;
    end
  end

  // result register, free again once its transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_area_r   <= res_area;
      out_cx_r     <= res_cx;
      out_cy_r     <= res_cy;
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_area   = out_area_r;
  assign out_cx     = out_cx_r;
  assign out_cy     = out_cy_r;
  assign out_status = out_status_r;

  // status to the controller
  assign stat.count_zero = (cnt_r == '0);
  assign stat.count_full = (cnt_r >= CNT_W'(MAX_VERTICES));
  assign stat.last       = cur_last_r;
  assign stat.need_div   = !ovf_r && cnt_gt3 && (cross_r != '0);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// ===== design/pca_ctrl.sv =====
// ----------------------------------------------------------------------------
// pca_ctrl
// Controller: sequences the per-vertex multiply and accumulate steps and the
// end-of-frame division and result load.
// ----------------------------------------------------------------------------
module pca_ctrl import pca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pca_stat_t stat,
  output pca_cmd_t  cmd
);

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE = 4'd0;
  localparam logic [STATE_W-1:0] S_VTX  = 4'd1;
  localparam logic [STATE_W-1:0] S_M2   = 4'd2;
  localparam logic [STATE_W-1:0] S_CR   = 4'd3;
  localparam logic [STATE_W-1:0] S_W1   = 4'd4;
  localparam logic [STATE_W-1:0] S_W2   = 4'd5;
  localparam logic [STATE_W-1:0] S_W3   = 4'd6;
  localparam logic [STATE_W-1:0] S_ENDV = 4'd7;
  localparam logic [STATE_W-1:0] S_FIN  = 4'd8;
  localparam logic [STATE_W-1:0] S_DIVS = 4'd9;
  localparam logic [STATE_W-1:0] S_DIVX = 4'd10;
  localparam logic [STATE_W-1:0] S_DIVY = 4'd11;
  localparam logic [STATE_W-1:0] S_OUT  = 4'd12;

  logic [STATE_W-1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_VTX;
        end
      end
      S_VTX: begin
        if (stat.count_full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = S_ENDV;
        end else if (stat.count_zero) begin
          cmd.vtx_first = 1'b1;
          cmd.advance   = 1'b1;
          state_nxt     = S_ENDV;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_PX_Y;
          state_nxt   = S_M2;
        end
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X_PY;
        cmd.hold_t  = 1'b1;
        state_nxt   = S_CR;
      end
      S_CR: begin
        cmd.calc_c = 1'b1;
        state_nxt  = S_W1;
      end
      S_W1: begin
        cmd.acc_cross = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_C_SX;
        state_nxt     = S_W2;
      end
      S_W2: begin
        cmd.acc_wx  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_C_SY;
        state_nxt   = S_W3;
      end
      S_W3: begin
        cmd.acc_wy  = 1'b1;
        cmd.advance = 1'b1;
        state_nxt   = S_ENDV;
      end
      S_ENDV: begin
        state_nxt = stat.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.load_den = 1'b1;
        state_nxt    = stat.need_div ? S_DIVS : S_OUT;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVX;
      end
      S_DIVX: begin
        if (stat.div_done) begin
          cmd.cap_cx    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_y = 1'b1;
          state_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (stat.div_done) begin
          cmd.cap_cy = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/polygon_centroid_area_unit.sv =====
// ----------------------------------------------------------------------------
// polygon_centroid_area_unit
// Shoelace area and centroid of a closed polygon frame, one vertex per
// transfer, one result per frame.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit first)        | side band
// in_     | in  | vertex_x, vertex_y           | tlast = last_vertex
// out_    | out | area, center_x, center_y     | tuser = status
//
// an ordinary vertex runs through the multiply and accumulate steps (one shared
// 33x17 multiplier used four times, plus accumulate steps); the first vertex and
// any vertex past the frame limit skip them
// a polygon frame then runs two centroid divisions of 59 quotient bits each and
// three setup and load steps before its result loads; any other frame goes
// straight from the setup step to the result load
// the result register lets the next frame start while a result waits
// synchronous active-low reset clears the frame state and the result valid
// ----------------------------------------------------------------------------
module polygon_centroid_area_unit import pca_pkg::*; #(
  parameter int MAX_VERTICES = VERTEX_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // vertex_x, vertex_y
  input  logic                    in_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,  // area, center_x, center_y
  output logic [STATUS_W-1:0]     out_tuser   // status
);

  pca_cmd_t                  cmd;
  pca_stat_t                 stat;
  logic signed [AREA_W-1:0]  area;
  logic signed [COORD_W-1:0] center_x, center_y;

  // controller
  pca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  pca_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_x       ($signed(in_tdata[COORD_W-1:0])),
    .in_y       ($signed(in_tdata[IN_TDATA_W-1:COORD_W])),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_area   (area),
    .out_cx     (center_x),
    .out_cy     (center_y),
    .out_status (out_tuser)
  );

  assign out_tdata = {center_y, center_x, area};

endmodule

// ===== design/pca_checker.sv =====
// ----------------------------------------------------------------------------
// pca_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pca_checker import pca_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only a real polygon reports an area
  a_area_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_POLYGON |-> out_tdata[AREA_W-1:0] == '0)
    else $error("nonzero area outside polygon case");

  // degenerate frames report a zero centroid
  a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ZERO_AREA || out_tuser == ST_TOO_FEW ||
                   out_tuser == ST_OVERFLOW)
    |-> out_tdata[OUT_DATA_W-1:AREA_W] == '0)
    else $error("nonzero centroid in degenerate case");

  // a closing vertex never produces a result in the very next cycle
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !$rose(out_tvalid))
    else $error("result too early after closing vertex");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind polygon_centroid_area_unit pca_checker u_pca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
